// ----- hw/rtl/nfcd_pkg.sv -----
// Shared types and constants for the contactless-reader receive deframer.
// Used by nfcd_core and nfc_reader_frame_deframer_top; depends on nothing.
package nfcd_pkg;

  // Input transaction: one received byte or a restart request.
  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  // Result transaction: one event per input item.
  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
  } out_item_t;

  // Mode codes.
  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Event codes.
  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_ACK  = 3'd1;
  localparam logic [2:0] EV_DATA = 3'd2;
  localparam logic [2:0] EV_GOOD = 3'd3;
  localparam logic [2:0] EV_LEN  = 3'd4;
  localparam logic [2:0] EV_ID   = 3'd5;
  localparam logic [2:0] EV_SUM  = 3'd6;
  localparam logic [2:0] EV_IDLE = 3'd7;

  // Frame bytes and register reset value.
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] BYTE_FF      = 8'hFF;
  localparam logic [7:0] FRAME_ID_RST = 8'hD5;

  // Acknowledge frame position of the last byte.
  localparam logic [2:0] ACK_LAST = 3'd5;

  // Exchange phase.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ACK  = 3'b010,
    PH_RESP = 3'b100
  } phase_t;

  // Position within the information frame.
  typedef enum logic [8:0] {
    RS_PRE  = 9'b000000001,
    RS_SC0  = 9'b000000010,
    RS_SC1  = 9'b000000100,
    RS_LEN  = 9'b000001000,
    RS_LCS  = 9'b000010000,
    RS_ID   = 9'b000100000,
    RS_DATA = 9'b001000000,
    RS_DCS  = 9'b010000000,
    RS_POST = 9'b100000000
  } resp_step_t;

endpackage

// ----- hw/rtl/nfc_reader_frame_deframer_top.sv -----
// Top level of the contactless-reader receive deframer.
// Depends on nfcd_pkg and nfcd_core.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one transaction per
//   received byte, or a restart that begins a new exchange. After a restart
//   the block hunts an acknowledge frame, then one information frame, and
//   reports one event per input transaction on the output channel
//   (out_valid, out_stall, out_data). Payload bytes are streamed with their
//   index.
//   Configuration channel (cfg_valid, cfg_ready, cfg_data) writes the
//   expected frame identifier; cfg_ready is always high. Write it only while
//   no results are pending.
//   A result is registered in the output register, or in the skid register
//   while the receiver stalls. Throughput is one transaction per cycle while
//   in_stall is low, set by the state update in the core. When the receiver
//   stalls, the output register holds its result and one more result lands
//   in a skid register; in_stall rises only while that skid register is full.
//   Synchronous reset clears the state to idle, empties both result
//   registers and restores the identifier to D5 hex.
module nfc_reader_frame_deframer_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  nfcd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nfcd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import nfcd_pkg::*;

  logic      accept;
  logic      out_free;
  logic      skid_valid;
  out_item_t skid_data;
  out_item_t result;

  assign in_stall  = skid_valid;
  assign accept    = in_valid & ~in_stall;
  assign out_free  = ~out_valid | ~out_stall;
  assign cfg_ready = 1'b1;

  // Per-byte decode and deframer state.
  nfcd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_data),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule

// ----- hw/rtl/nfcd_core.sv -----
// Deframer state and per-byte decode for the contactless-reader receiver.
// Depends on nfcd_pkg; produces one result per accepted input transaction.
module nfcd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  nfcd_pkg::in_item_t  item,
  input  logic              cfg_write,
  input  logic [7:0]        cfg_data,
  output nfcd_pkg::out_item_t result
);
  import nfcd_pkg::*;

  logic [7:0] expected_frame_id;
  phase_t     phase, phase_next;
  logic [2:0] ack_step, ack_step_next;
  resp_step_t resp_step, resp_step_next;
  logic [7:0] length_seen, length_seen_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] b;
  logic [7:0] ack_expect;
  logic [7:0] count_inc;
  logic [8:0] count_ahead;

  assign b           = item.rx_byte;
  assign count_inc   = byte_count + 8'd1;
  assign count_ahead = {1'b0, count_inc} + 9'd1;

  // Expected byte of the acknowledge frame at each position.
  always_comb begin
    case (ack_step)
      3'd2:    ack_expect = BYTE_FF;
      3'd4:    ack_expect = BYTE_FF;
      default: ack_expect = BYTE_ZERO;
    endcase
  end

  // Next state and result for the current byte.
  always_comb begin
    phase_next       = phase;
    ack_step_next    = ack_step;
    resp_step_next   = resp_step;
    length_seen_next = length_seen;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    result.event_res     = EV_NONE;
    result.payload_byte  = BYTE_ZERO;
    result.payload_index = BYTE_ZERO;

    if (item.mode == MODE_RESTART) begin
      phase_next       = PH_ACK;
      ack_step_next    = 3'd0;
      resp_step_next   = RS_PRE;
      length_seen_next = BYTE_ZERO;
      byte_count_next  = BYTE_ZERO;
      running_sum_next = BYTE_ZERO;
    end else begin
      case (phase)
        PH_ACK: begin
          if (ack_step == 3'd0 || ack_step > ACK_LAST) begin
            // Hunting the first zero of the acknowledge frame.
            ack_step_next = (b == BYTE_ZERO) ? 3'd1 : 3'd0;
          end else if (b != ack_expect) begin
            ack_step_next = 3'd0;
          end else if (ack_step == ACK_LAST) begin
            ack_step_next    = 3'd0;
            phase_next       = PH_RESP;
            resp_step_next   = RS_PRE;
            result.event_res = EV_ACK;
          end else begin
            ack_step_next = ack_step + 3'd1;
          end
        end
        PH_RESP: begin
          case (resp_step)
            RS_SC0: resp_step_next = (b == BYTE_ZERO) ? RS_SC1 : RS_PRE;
            RS_SC1: resp_step_next = (b == BYTE_FF) ? RS_LEN : RS_PRE;
            RS_LEN: begin
              length_seen_next = b;
              resp_step_next   = RS_LCS;
            end
            RS_LCS: begin
              if ((length_seen + b) != BYTE_ZERO || length_seen == BYTE_ZERO) begin
                resp_step_next   = RS_PRE;
                result.event_res = EV_LEN;
              end else begin
                resp_step_next = RS_ID;
              end
            end
            RS_ID: begin
              if (b != expected_frame_id) begin
                resp_step_next   = RS_PRE;
                result.event_res = EV_ID;
              end else begin
                running_sum_next = b;
                byte_count_next  = BYTE_ZERO;
                resp_step_next   = (length_seen == 8'd1) ? RS_DCS : RS_DATA;
              end
            end
            RS_DATA: begin
              // Stream the payload byte out with its index.
              result.event_res     = EV_DATA;
              result.payload_byte  = b;
              result.payload_index = byte_count;
              running_sum_next     = running_sum + b;
              byte_count_next      = count_inc;
              if (count_ahead >= {1'b0, length_seen}) begin
                resp_step_next = RS_DCS;
              end
            end
            RS_DCS: begin
              if ((running_sum + b) != BYTE_ZERO) begin
                resp_step_next   = RS_PRE;
                result.event_res = EV_SUM;
              end else begin
                resp_step_next = RS_POST;
              end
            end
            RS_POST: begin
              resp_step_next = RS_PRE;
              if (b == BYTE_ZERO) begin
                phase_next       = PH_IDLE;
                result.event_res = EV_GOOD;
              end
            end
            default: resp_step_next = (b == BYTE_ZERO) ? RS_SC0 : RS_PRE;
          endcase
        end
        default: result.event_res = EV_IDLE;
      endcase
    end
    result.frame_length = length_seen_next;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_frame_id <= FRAME_ID_RST;
    end else if (cfg_write) begin
      expected_frame_id <= cfg_data;
    end
  end

  // Deframer state, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      ack_step    <= 3'd0;
      resp_step   <= RS_PRE;
      length_seen <= BYTE_ZERO;
      byte_count  <= BYTE_ZERO;
      running_sum <= BYTE_ZERO;
    end else if (accept) begin
      phase       <= phase_next;
      ack_step    <= ack_step_next;
      resp_step   <= resp_step_next;
      length_seen <= length_seen_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

endmodule
